/* sv/frustum_cull_test_top_defines.svh */
// Assertion macros for the frustum cull test block.
`ifndef FRUSTUM_CULL_TEST_TOP_DEFINES_SVH
`define FRUSTUM_CULL_TEST_TOP_DEFINES_SVH

// same-cycle implication on the block clock, disabled in reset
`define FCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frustum cull check failed");

// implication with a fixed delay in cycles
`define FCT_ASSERT_DLY(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("frustum cull latency check failed");

`endif

/* sv/fct_pkg.sv */
// Shared types and constants for the frustum cull test block.
package fct_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int PLANE_CNT       = 6;
    localparam int PLANE_W         = 64;
    localparam int COEF_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int REQ_W           = 3;
    localparam int FRAC_SHIFT      = 14;   // aligns d and radius to the dot format
    localparam int PIPE_LAT        = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR   = 3'd0,
        CFG_FAR    = 3'd1,
        CFG_LEFT   = 3'd2,
        CFG_RIGHT  = 3'd3,
        CFG_TOP    = 3'd4,
        CFG_BOTTOM = 3'd5
    } t_cfg_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_POINT  = 3'd0,
        REQ_SPHERE = 3'd1,
        REQ_CUBE   = 3'd2,
        REQ_RECT   = 3'd3,
        REQ_AABB   = 3'd4,
        REQ_BOTH   = 3'd5
    } t_req_type;

    typedef struct packed {
        logic vld;
        logic chk_pt;    // point or sphere test on the center
        logic chk_box;   // box test on the min/max corners
    } t_ctrl;

endpackage

/* sv/fct_plane_dist.sv */
// One plane: p-vertex products, then the two plane distances, two register stages.
module fct_plane_dist import fct_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int DIST_W      = 34
) (
    input  logic                            i_clk,
    input  logic [PLANE_W-1:0]              i_plane,
    input  logic signed [COORD_WIDTH:0]     i_pt   [3],
    input  logic signed [COORD_WIDTH:0]     i_bmin [3],
    input  logic signed [COORD_WIDTH:0]     i_bmax [3],
    output logic signed [DIST_W-1:0]        o_pt_dist,
    output logic signed [DIST_W-1:0]        o_box_dist
);

    localparam int XW = COORD_WIDTH + 1;
    localparam int PW = XW + COEF_W;

    logic signed [COEF_W-1:0] coef [3];
    logic signed [COEF_W-1:0] d_coef;
    logic signed [XW-1:0]     pv   [3];
    logic signed [PW-1:0]     n_pt_prod  [3];
    logic signed [PW-1:0]     n_box_prod [3];
    logic signed [PW-1:0]     r_pt_prod  [3];
    logic signed [PW-1:0]     r_box_prod [3];
    logic signed [DIST_W-1:0] d_term;
    logic signed [DIST_W-1:0] n_pt_dist;
    logic signed [DIST_W-1:0] n_box_dist;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            coef[k] = i_plane[COEF_W*k +: COEF_W];
            // p-vertex: larger end for a positive coefficient, smaller for a negative one
            pv[k] = coef[k][COEF_W-1] ? i_bmin[k] : i_bmax[k];
            n_pt_prod[k]  = PW'(coef[k]) * PW'(i_pt[k]);
            n_box_prod[k] = PW'(coef[k]) * PW'(pv[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt_prod  <= n_pt_prod;
        r_box_prod <= n_box_prod;
    end

    assign d_coef = i_plane[COEF_W*3 +: COEF_W];
    assign d_term = DIST_W'(d_coef) <<< FRAC_SHIFT;

    always_comb begin
        n_pt_dist  = d_term + DIST_W'(r_pt_prod[0]) + DIST_W'(r_pt_prod[1])
                   + DIST_W'(r_pt_prod[2]);
        n_box_dist = d_term + DIST_W'(r_box_prod[0]) + DIST_W'(r_box_prod[1])
                   + DIST_W'(r_box_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        o_pt_dist  <= n_pt_dist;
        o_box_dist <= n_box_dist;
    end

endmodule

/* sv/frustum_cull_test_top.sv */
// Frustum cull test top: six-plane visibility test for points, spheres and boxes.
// Timing: o_valid follows the start through r_ctl1, r_ctl2, r_ctl3 and o_valid; one word per clock.
// Stages: corner setup, 36 plane products, plane sums, compare and reduce.
// busy stays low; the pipeline never stalls since results cannot be held off.
// Sync active-low reset clears the pipeline valids and all six planes to zero.
`include "frustum_cull_test_top_defines.svh"

module frustum_cull_test_top import fct_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [REQ_W-1:0]              i_req_type,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_cz,
    input  logic signed [COORD_WIDTH-1:0] i_radius,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_az,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_bz,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [PLANE_W-1:0]            i_cfg_data,
    output logic                          o_valid,
    output logic                          o_visible
);

    localparam int XW     = COORD_WIDTH + 1;
    localparam int PW     = XW + COEF_W;
    localparam int DW_MIN = (PW > COEF_W + FRAC_SHIFT) ? PW : COEF_W + FRAC_SHIFT;
    localparam int DIST_W = DW_MIN + 2;

    logic [PLANE_W-1:0] r_plane [PLANE_CNT];

    logic signed [XW-1:0]     c_e [3];
    logic signed [XW-1:0]     a_e [3];
    logic signed [XW-1:0]     b_e [3];
    logic signed [XW-1:0]     r_e;
    logic signed [XW-1:0]     lo  [3];
    logic signed [XW-1:0]     hi  [3];
    logic signed [XW-1:0]     n_bmin [3];
    logic signed [XW-1:0]     n_bmax [3];
    logic signed [XW-1:0]     r_bmin [3];
    logic signed [XW-1:0]     r_bmax [3];
    logic signed [XW-1:0]     r_pt   [3];
    logic signed [DIST_W-1:0] n_bound;
    logic signed [DIST_W-1:0] r_bound1;
    logic signed [DIST_W-1:0] r_bound2;
    logic signed [DIST_W-1:0] r_bound3;
    logic signed [DIST_W-1:0] pt_dist  [PLANE_CNT];
    logic signed [DIST_W-1:0] box_dist [PLANE_CNT];
    t_ctrl                    n_ctl;
    t_ctrl                    r_ctl1;
    t_ctrl                    r_ctl2;
    t_ctrl                    r_ctl3;
    logic                     rej_pt;
    logic                     rej_box;
    logic                     n_visible;
    logic                     accept;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_CNT; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index <= CFG_BOTTOM)) begin
            r_plane[i_cfg_index] <= i_cfg_data;
        end
    end

    // stage 1: corner setup
    always_comb begin
        c_e[0] = XW'(i_cx);  c_e[1] = XW'(i_cy);  c_e[2] = XW'(i_cz);
        a_e[0] = XW'(i_ax);  a_e[1] = XW'(i_ay);  a_e[2] = XW'(i_az);
        b_e[0] = XW'(i_bx);  b_e[1] = XW'(i_by);  b_e[2] = XW'(i_bz);
        r_e    = XW'(i_radius);
        n_ctl     = '0;
        n_ctl.vld = accept;
        n_bound   = '0;
        lo        = c_e;
        hi        = c_e;
        unique case (t_req_type'(i_req_type))
            REQ_POINT: begin
                n_ctl.chk_pt = 1'b1;
            end
            REQ_SPHERE: begin
                n_ctl.chk_pt = 1'b1;
                n_bound      = -(DIST_W'(i_radius) <<< FRAC_SHIFT);
            end
            REQ_CUBE: begin
                n_ctl.chk_box = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    lo[k] = c_e[k] - r_e;
                    hi[k] = c_e[k] + r_e;
                end
            end
            REQ_RECT: begin
                n_ctl.chk_box = 1'b1;
                for (int k = 0; k < 3; k++) begin
                    lo[k] = c_e[k] - b_e[k];
                    hi[k] = c_e[k] + b_e[k];
                end
            end
            REQ_AABB: begin
                n_ctl.chk_box = 1'b1;
                lo = a_e;
                hi = b_e;
            end
            REQ_BOTH: begin
                n_ctl.chk_pt  = 1'b1;
                n_ctl.chk_box = 1'b1;
                n_bound       = -(DIST_W'(i_radius) <<< FRAC_SHIFT);
                lo = a_e;
                hi = b_e;
            end
            default: begin
                // reserved types: no test, reported visible
            end
        endcase
        // either end may be the larger one
        for (int k = 0; k < 3; k++) begin
            n_bmin[k] = (lo[k] < hi[k]) ? lo[k] : hi[k];
            n_bmax[k] = (lo[k] < hi[k]) ? hi[k] : lo[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt     <= c_e;
        r_bmin   <= n_bmin;
        r_bmax   <= n_bmax;
        r_bound1 <= n_bound;
        r_bound2 <= r_bound1;
        r_bound3 <= r_bound2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1  <= '0;
            r_ctl2  <= '0;
            r_ctl3  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_ctl1  <= n_ctl;
            r_ctl2  <= r_ctl1;
            r_ctl3  <= r_ctl2;
            o_valid <= r_ctl3.vld;
        end
    end

    // stages 2 and 3: per-plane products and sums
    for (genvar p = 0; p < PLANE_CNT; p++) begin : g_plane
        fct_plane_dist #(
            .COORD_WIDTH (COORD_WIDTH),
            .DIST_W      (DIST_W)
        ) u_dist (
            .i_clk      (i_clk),
            .i_plane    (r_plane[p]),
            .i_pt       (r_pt),
            .i_bmin     (r_bmin),
            .i_bmax     (r_bmax),
            .o_pt_dist  (pt_dist[p]),
            .o_box_dist (box_dist[p])
        );
    end

    // stage 4: compare and reduce over the planes
    always_comb begin
        rej_pt  = 1'b0;
        rej_box = 1'b0;
        for (int p = 0; p < PLANE_CNT; p++) begin
            rej_pt  = rej_pt  | (pt_dist[p] < r_bound3);
            rej_box = rej_box | box_dist[p][DIST_W-1];
        end
        n_visible = !(r_ctl3.chk_pt && rej_pt) && !(r_ctl3.chk_box && rej_box);
    end

    always_ff @(posedge i_clk) begin
        o_visible <= n_visible;
    end

    `FCT_ASSERT_DLY(a_start_to_strobe, accept, 4, o_valid)
    `FCT_ASSERT_NOW(a_strobe_from_start, o_valid, $past(accept, PIPE_LAT))
    `FCT_ASSERT_DLY(a_reserved_visible, accept && (i_req_type > REQ_BOTH), 4, o_visible)

endmodule
